// ===== sv/nsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the note value table for the note span decomposer.
// No dependencies; imported by nsd_divu, the top level and the bench.
package nsd_pkg;

    localparam int START_W = 19;
    localparam int SPAN_W  = 13;
    localparam int BAR_W   = 13;
    localparam int GROUP_W = 12;
    localparam int PIECE_W = 12;
    localparam int PITCH_W = 7;
    localparam int POS_W   = 20;
    localparam int CNT_W   = 4;

    localparam logic [CNT_W-1:0]   LAST_PIECE  = 4'd15;
    localparam logic [SPAN_W-1:0]  LEN_MAX     = 13'd4095;
    localparam logic [BAR_W-1:0]   BAR_RESET   = 13'd3840;
    localparam logic [GROUP_W-1:0] GROUP_RESET = 12'd960;

    localparam logic CFG_BAR   = 1'b0;
    localparam logic CFG_GROUP = 1'b1;

    localparam logic [PIECE_W-1:0] VALUE_TABLE [8] = '{
        12'd3840, 12'd2880, 12'd1920, 12'd1440, 12'd960, 12'd720, 12'd480, 12'd240
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BMOD,
        ST_GCHK,
        ST_GMOD,
        ST_PIECE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [POS_W-1:0]  dividend;
        logic [BAR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [BAR_W-1:0]  rem;
    } t_div_rsp;

    // Largest table value not above the allowed length; zero if none fits.
    function automatic logic [PIECE_W-1:0] pick_value(input logic [SPAN_W-1:0] allowed);
        logic [PIECE_W-1:0] v;
        v = '0;
        for (int i = 7; i >= 0; i--) begin
            if ({1'b0, VALUE_TABLE[i]} <= allowed) begin
                v = VALUE_TABLE[i];
            end
        end
        return v;
    endfunction

endpackage

// ===== sv/nsd_divu.sv =====
`timescale 1ns / 1ps
// Restoring remainder unit, one quotient bit per cycle, shared for bar and group modulo.
// Depends on nsd_pkg.
module nsd_divu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nsd_pkg::t_div_req i_req,
    output nsd_pkg::t_div_rsp o_rsp
);
    import nsd_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(POS_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [BAR_W-1:0]   r_rem;
    logic [POS_W-1:0]   r_dvd;
    logic [BAR_W-1:0]   r_dvs;
    logic [BAR_W:0]     w_shift;
    logic [BAR_W:0]     w_diff;
    logic [BAR_W-1:0]   n_rem;

    always_comb begin
        w_shift = {r_rem, r_dvd[POS_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        if (w_shift >= {1'b0, r_dvs}) begin
            n_rem = w_diff[BAR_W-1:0];
        end else begin
            n_rem = w_shift[BAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[POS_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== sv/note_span_decomposer_top.sv =====
`timescale 1ns / 1ps
// Top level of the note span decomposer: handshakes, configuration, sequencer, output beat.
// Depends on nsd_pkg and nsd_divu.
//
// One span is taken at a time; o_in_ready is high only while the sequencer is idle. A span
// first runs the position-in-bar modulo (skipped when bar_length is zero), then each piece
// runs the group modulo and then issues its beat once the output register is free (the
// group modulo is skipped when group_length is zero). Both moduli run on one shared 20-bit
// restoring remainder unit, one bit per cycle.
// The last piece sits in the output register while the next span is accepted.
module note_span_decomposer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [nsd_pkg::BAR_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nsd_pkg::START_W-1:0]   i_start_tick,
    input  logic [nsd_pkg::SPAN_W-1:0]    i_span_length,
    input  logic [nsd_pkg::PITCH_W-1:0]   i_pitch,
    input  logic                          i_is_rest,
    input  logic                          i_tie_out,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nsd_pkg::START_W-1:0]   o_piece_start,
    output logic [nsd_pkg::PIECE_W-1:0]   o_piece_length,
    output logic [nsd_pkg::PITCH_W-1:0]   o_piece_pitch,
    output logic                          o_piece_rest,
    output logic                          o_tied_to_next,
    output logic                          o_clipped,
    output logic                          o_last
);
    import nsd_pkg::*;

    t_state             r_state, n_state;
    logic [BAR_W-1:0]   r_bar;
    logic [GROUP_W-1:0] r_group;
    logic [START_W-1:0] r_pos;
    logic [POS_W-1:0]   r_in_bar;
    logic [SPAN_W-1:0]  r_remaining;
    logic [GROUP_W-1:0] r_gmod;
    logic [CNT_W-1:0]   r_count;
    logic [PITCH_W-1:0] r_pitch;
    logic               r_rest;
    logic               r_tie;
    logic               r_cut;
    logic               r_out_valid;

    t_div_req           w_req;
    t_div_rsp           w_rsp;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_emit;
    logic [BAR_W-1:0]   w_to_end;
    logic [GROUP_W-1:0] w_to_edge;
    logic [SPAN_W-1:0]  w_allowed;
    logic [PIECE_W-1:0] w_value;
    logic [SPAN_W-1:0]  w_piece;
    logic               w_piece_cut;
    logic               w_is_last;

    nsd_divu u_divu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_to_end   = r_bar - w_rsp.rem;
    assign w_to_edge  = r_group - r_gmod;

    // Piece length for the current position.
    always_comb begin
        w_allowed = r_remaining;
        if (r_group != '0 && r_gmod != '0 && {1'b0, w_to_edge} < w_allowed) begin
            w_allowed = {1'b0, w_to_edge};
        end
        w_value     = pick_value(w_allowed);
        w_piece     = (w_value != '0) ? {1'b0, w_value} : r_remaining;
        w_piece_cut = 1'b0;
        if (r_count == LAST_PIECE) begin
            w_piece = r_remaining;
            if (r_remaining > LEN_MAX) begin
                w_piece     = LEN_MAX;
                w_piece_cut = 1'b1;
            end
            w_is_last = 1'b1;
        end else begin
            if (w_piece > LEN_MAX) begin
                w_piece = LEN_MAX;
            end
            w_is_last = (r_remaining == w_piece);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_span_length != '0) begin
                    n_state = (r_bar != '0) ? ST_BMOD : ST_GCHK;
                end
            end
            ST_BMOD: begin
                if (w_rsp.done) begin
                    n_state = ST_GCHK;
                end
            end
            ST_GCHK: begin
                n_state = (r_group != '0) ? ST_GMOD : ST_PIECE;
            end
            ST_GMOD: begin
                if (w_rsp.done) begin
                    n_state = ST_PIECE;
                end
            end
            ST_PIECE: begin
                if (w_out_free) begin
                    n_state = w_is_last ? ST_IDLE : ST_GCHK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        w_emit       = 1'b0;
        w_req.start    = 1'b0;
        w_req.dividend = r_in_bar;
        w_req.divisor  = {1'b0, r_group};
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                w_req.start    = i_in_valid && i_span_length != '0 && r_bar != '0;
                w_req.dividend = {1'b0, i_start_tick};
                w_req.divisor  = r_bar;
            end
            ST_GCHK: begin
                w_req.start = (r_group != '0);
            end
            ST_PIECE: begin
                w_emit = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bar       <= BAR_RESET;
            r_group     <= GROUP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_BAR:   r_bar   <= i_cfg_data;
                    CFG_GROUP: r_group <= i_cfg_data[GROUP_W-1:0];
                    default: ;
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_pos       <= i_start_tick;
                    r_in_bar    <= {1'b0, i_start_tick};
                    r_remaining <= i_span_length;
                    r_pitch     <= i_pitch;
                    r_rest      <= i_is_rest;
                    r_tie       <= i_tie_out;
                    r_cut       <= 1'b0;
                    r_count     <= '0;
                end
            end
            ST_BMOD: begin
                if (w_rsp.done) begin
                    r_in_bar <= {{(POS_W-BAR_W){1'b0}}, w_rsp.rem};
                    if (r_remaining > w_to_end) begin
                        r_remaining <= w_to_end;
                        r_cut       <= 1'b1;
                    end
                end
            end
            ST_GCHK: begin
                r_gmod <= '0;
            end
            ST_GMOD: begin
                if (w_rsp.done) begin
                    r_gmod <= w_rsp.rem[GROUP_W-1:0];
                end
            end
            ST_PIECE: begin
                if (w_emit) begin
                    r_pos       <= r_pos + START_W'(w_piece);
                    r_in_bar    <= r_in_bar + POS_W'(w_piece);
                    r_remaining <= r_remaining - w_piece;
                    r_count     <= r_count + 4'd1;
                end
            end
            default: ;
        endcase
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_piece_start  <= r_pos;
            o_piece_length <= w_piece[PIECE_W-1:0];
            o_piece_pitch  <= r_pitch;
            o_piece_rest   <= r_rest;
            o_tied_to_next <= r_rest ? 1'b0 : (w_is_last ? r_tie : 1'b1);
            o_clipped      <= w_is_last && (r_cut || w_piece_cut);
            o_last         <= w_is_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/nsd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the note span decomposer, bound to the top level.
// Depends on note_span_decomposer_top ports only.
module nsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [12:0] i_span_length,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [18:0] o_piece_start,
    input logic [11:0] o_piece_length,
    input logic        o_piece_rest,
    input logic        o_tied_to_next,
    input logic        o_clipped,
    input logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_piece_start)
            && $stable(o_piece_length) && $stable(o_last))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_span_length != 13'd0 |=> !o_in_ready)
        else $error("span accepted while another is in work");

    a_nonzero_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_piece_length != 12'd0)
        else $error("zero length piece");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_piece_rest && o_tied_to_next) && (!o_clipped || o_last))
        else $error("tie on rest or clip off the last piece");

endmodule

bind note_span_decomposer_top nsd_checker u_nsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_span_length  (i_span_length),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_piece_start  (o_piece_start),
    .o_piece_length (o_piece_length),
    .o_piece_rest   (o_piece_rest),
    .o_tied_to_next (o_tied_to_next),
    .o_clipped      (o_clipped),
    .o_last         (o_last)
);

// ===== bench/tb_note_span_decomposer_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for note_span_decomposer_top: queued spans, a span splitter that
// predicts each piece beat, random stalls on both channels. Depends on nsd_pkg and the RTL.
module tb_note_span_decomposer_top;
    import nsd_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 500;
    localparam int RANDOM_SPANS  = 52;
    localparam int NUM_METERS    = 9;
    localparam int MAX_BARS      = 64;
    localparam int MAX_PIECES    = 16;
    localparam int LEN_LIMIT     = 4095;
    localparam int MAX_PRINTS    = 200;

    typedef struct {
        logic [START_W-1:0] start;
        logic [SPAN_W-1:0]  length;
        logic [PITCH_W-1:0] pitch;
        logic               rest;
        logic               tie;
    } t_span;

    typedef struct {
        logic [START_W-1:0] start;
        logic [PIECE_W-1:0] length;
        logic [PITCH_W-1:0] pitch;
        logic               rest;
        logic               tied;
        logic               clipped;
        logic               last;
    } t_piece;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_addr = CFG_BAR;
    logic [BAR_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic [START_W-1:0]   start_tick = '0;
    logic [SPAN_W-1:0]    span_length = '0;
    logic [PITCH_W-1:0]   pitch = '0;
    logic                 is_rest = 1'b0;
    logic                 tie_out = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [START_W-1:0]   o_piece_start;
    logic [PIECE_W-1:0]   o_piece_length;
    logic [PITCH_W-1:0]   o_piece_pitch;
    logic                 o_piece_rest;
    logic                 o_tied_to_next;
    logic                 o_clipped;
    logic                 o_last;

    logic [BAR_W-1:0]     bar_cfg = 13'd3840;
    logic [GROUP_W-1:0]   grp_cfg = 12'd960;
    int unsigned          note_values [8] = '{3840, 2880, 1920, 1440, 960, 720, 480, 240};
    int unsigned          meter_bars [NUM_METERS] =
        '{2880, 5760, 240, 8191, 0, 1000, 3840, 5760, 3840};
    int unsigned          meter_groups [NUM_METERS] =
        '{960, 1440, 0, 4095, 480, 100, 1, 3840, 960};

    t_span                span_q [$];
    t_piece               piece_q [$];
    t_span                cur_span;
    t_piece               want;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   errors = 0;
    int                   beats_seen = 0;
    int                   cycle_count = 0;

    note_span_decomposer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_tick   (start_tick),
        .i_span_length  (span_length),
        .i_pitch        (pitch),
        .i_is_rest      (is_rest),
        .i_tie_out      (tie_out),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_piece_start  (o_piece_start),
        .o_piece_length (o_piece_length),
        .o_piece_pitch  (o_piece_pitch),
        .o_piece_rest   (o_piece_rest),
        .o_tied_to_next (o_tied_to_next),
        .o_clipped      (o_clipped),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            flag_mismatch($sformatf("beat %0d %s: got %0d, want %0d",
                                    beats_seen, name, got, exp_val));
        end
    endtask

    // Cut at the bar end, then split greedily under the off-beat group rule.
    function automatic void split_span(input t_span s);
        longint unsigned bar, grp, pos, len, remaining, bar_end, in_bar, allowed, piece;
        longint unsigned to_edge, v;
        bit              cut, piece_cut, is_last;
        int              count;
        t_piece          p;
        bar   = 64'(bar_cfg);
        grp   = 64'(grp_cfg);
        pos   = 64'(s.start);
        len   = 64'(s.length);
        cut   = 1'b0;
        count = 0;
        if (len == 0) begin
            return;
        end
        if (bar != 0) begin
            bar_end = (pos / bar + 1) * bar;
            if (pos + len > bar_end) begin
                len = bar_end - pos;
                cut = 1'b1;
            end
        end
        remaining = len;
        while (remaining > 0) begin
            in_bar    = (bar != 0) ? pos % bar : pos;
            allowed   = remaining;
            piece_cut = 1'b0;
            if (grp != 0 && (in_bar % grp) != 0) begin
                to_edge = grp - (in_bar % grp);
                if (to_edge < allowed) begin
                    allowed = to_edge;
                end
            end
            v = 0;
            for (int i = 0; i < 8 && v == 0; i++) begin
                if (64'(note_values[i]) <= allowed) begin
                    v = 64'(note_values[i]);
                end
            end
            piece = (v != 0 && v < remaining) ? v : remaining;
            if (count == MAX_PIECES - 1) begin
                piece = remaining;
                if (piece > 64'(LEN_LIMIT)) begin
                    piece     = 64'(LEN_LIMIT);
                    piece_cut = 1'b1;
                end
                remaining = piece;
            end else if (piece > 64'(LEN_LIMIT)) begin
                piece = 64'(LEN_LIMIT);
            end
            is_last   = (remaining == piece);
            p.start   = START_W'(pos);
            p.length  = PIECE_W'(piece);
            p.pitch   = s.pitch;
            p.rest    = s.rest;
            p.tied    = s.rest ? 1'b0 : (is_last ? s.tie : 1'b1);
            p.clipped = is_last && (cut || piece_cut);
            p.last    = is_last;
            piece_q.insert(piece_q.size(), p);
            count++;
            pos       += piece;
            remaining -= piece;
        end
    endfunction

    function automatic void push_span(input logic [START_W-1:0] st, input logic [SPAN_W-1:0] ln,
                                      input logic [PITCH_W-1:0] pt, input logic rs,
                                      input logic te);
        t_span s;
        s.start  = st;
        s.length = ln;
        s.pitch  = pt;
        s.rest   = rs;
        s.tie    = te;
        span_q.insert(span_q.size(), s);
    endfunction

    // Mostly grid-aligned spans inside one bar, some longer ones, some raw noise.
    function automatic void push_random_span();
        int unsigned bar, offset, room, pick, st, ln;
        logic [31:0] bits;
        bar    = (bar_cfg == 0) ? 3840 : 32'(bar_cfg);
        pick   = $urandom_range(99);
        bits   = $urandom;
        offset = 240 * $urandom_range((bar - 1) / 240);
        room   = (bar - offset) / 240;
        if (room == 0) begin
            room = 1;
        end
        st = $urandom_range(MAX_BARS - 1) * bar + offset;
        if (pick < 70) begin
            ln = 240 * $urandom_range(1, room);
        end else if (pick < 85) begin
            ln = 240 * $urandom_range(1, 34);
        end else begin
            st = $urandom;
            ln = $urandom_range(0, 8191);
        end
        push_span(START_W'(st), SPAN_W'(ln), bits[6:0], bits[7], bits[8]);
    endfunction

    task automatic set_meter(input logic [BAR_W-1:0] bar, input logic [GROUP_W-1:0] grp);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_BAR;
        cfg_data <= bar;
        @(posedge i_clk);
        cfg_addr <= CFG_GROUP;
        cfg_data <= {1'b0, grp};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        bar_cfg  = bar;
        grp_cfg  = grp;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (span_q.size() != 0 || in_valid || piece_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("note_span_decomposer_top verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                split_span(cur_span);
            end
            if (!in_valid || o_in_ready) begin
                if (span_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_span    = span_q.pop_front();
                    in_valid    <= 1'b1;
                    start_tick  <= cur_span.start;
                    span_length <= cur_span.length;
                    pitch       <= cur_span.pitch;
                    is_rest     <= cur_span.rest;
                    tie_out     <= cur_span.tie;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (piece_q.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d unexpected, start %0d",
                                            beats_seen, o_piece_start));
                end else begin
                    want = piece_q.pop_front();
                    check_field("piece_start", 32'(o_piece_start), 32'(want.start));
                    check_field("piece_length", 32'(o_piece_length), 32'(want.length));
                    check_field("piece_pitch", 32'(o_piece_pitch), 32'(want.pitch));
                    check_field("piece_rest", 32'(o_piece_rest), 32'(want.rest));
                    check_field("tied_to_next", 32'(o_tied_to_next), 32'(want.tied));
                    check_field("clipped", 32'(o_clipped), 32'(want.clipped));
                    check_field("last", 32'(o_last), 32'(want.last));
                end
                beats_seen++;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        send_idle_pct = 6;
        recv_idle_pct = 59;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_span(19'd0, 13'd3840, 7'd0, 1'b0, 1'b0);
        push_span(19'd3840, 13'd3840, 7'd127, 1'b1, 1'b1);
        push_span(19'd100, 13'd0, 7'd60, 1'b0, 1'b1);
        push_span(19'd240, 13'd1920, 7'd64, 1'b0, 1'b1);
        push_span(19'd3600, 13'd960, 7'd72, 1'b0, 1'b0);
        push_span(19'd7680, 13'd100, 7'd10, 1'b0, 1'b1);
        push_span(19'h7FFFF, 13'h1FFF, 7'd127, 1'b0, 1'b1);
        push_span(19'd0, 13'h1FFF, 7'd0, 1'b1, 1'b0);
        push_span(19'd4800, 13'd2400, 7'd55, 1'b0, 1'b1);
        push_span(19'd1, 13'd1, 7'd1, 1'b1, 1'b1);
        drain();

        set_meter(13'd0, 12'd100);
        push_span(19'd1, 13'd8191, 7'd33, 1'b0, 1'b1);
        push_span(19'd0, 13'd8191, 7'd34, 1'b1, 1'b0);
        push_span(19'h7FF00, 13'd8191, 7'd35, 1'b0, 1'b0);
        push_span(19'd50, 13'd0, 7'd0, 1'b0, 1'b0);
        drain();

        for (int m = 0; m < NUM_METERS; m++) begin
            if (m < 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 59;
            end else if (m < 6) begin
                send_idle_pct = 59;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_meter(BAR_W'(meter_bars[m]), GROUP_W'(meter_groups[m]));
            repeat (RANDOM_SPANS) push_random_span();
            drain();
        end

        if (errors == 0 && piece_q.size() == 0) begin
            $display("note_span_decomposer_top verification clean");
        end else begin
            $display("note_span_decomposer_top verification failed");
        end
        $finish;
    end

endmodule
